@@ src/wlv_pkg.sv @@
// ---------------------------------------------------------------------------
// wlv_pkg
// Shared types and constants for the windowed local variance block.
// ---------------------------------------------------------------------------
`default_nettype none

package wlv_pkg;

  localparam int MAX_TILE_DEF  = 16;
  localparam int MAX_WIDTH_DEF = 2048;

  localparam int PIX_W        = 8;
  localparam int VAR_W        = 22;
  localparam int OUT_TDATA_W  = 24;
  localparam int ROW_W        = 17;
  localparam int QCNT_W       = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int FW_W         = 12;
  localparam int FH_W         = 16;
  localparam int TS_W         = 5;

  localparam logic [FW_W-1:0] FW_RESET = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET = 16'd480;
  localparam logic [TS_W-1:0] TS_RESET = 5'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPD,
    ST_MUL,
    ST_SUB,
    ST_DIV,
    ST_OUT
  } wlv_state_e;

endpackage

`default_nettype wire

@@ src/windowed_local_variance.sv @@
// Sequencing: a pixel that yields a result passes READ, UPD, MUL, SUB, DIV
// and OUT in order; the 22 steps of the restoring divider set most of that.
// Throughput: a new pixel is taken only in IDLE, once the last one has left
// UPD or, when a result is due, OUT; the output register lets the next pixel in meanwhile.
// Reset: asynchronous, clears control state and counters; line and column
// stores are not cleared.
// ---------------------------------------------------------------------------
// windowed_local_variance
// Box-filter local variance over a tile_size square window, with line and
// column-sum stores in synchronous RAM and a serial divider.
// ---------------------------------------------------------------------------
`default_nettype none

module windowed_local_variance #(
  parameter int MAX_TILE  = wlv_pkg::MAX_TILE_DEF,
  parameter int MAX_WIDTH = wlv_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire logic [wlv_pkg::PIX_W-1:0]        s_axis_tdata_i,   // [7:0] pixel
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  output logic [wlv_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o,   // [21:0] variance_q8
  output logic                                  m_axis_tlast_o,   // frame_last
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [wlv_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [wlv_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import wlv_pkg::*;

  localparam int PW   = MAX_WIDTH + MAX_TILE - 1;
  localparam int CW   = $clog2(PW + 1);
  localparam int CAW  = $clog2(PW);
  localparam int TW   = $clog2(MAX_TILE + 1);
  localparam int SLW  = (MAX_TILE > 1) ? $clog2(MAX_TILE) : 1;
  localparam int LAW  = $clog2(MAX_TILE * PW);
  localparam int CSW  = $clog2(MAX_TILE * 255 + 1);
  localparam int CQW  = $clog2(MAX_TILE * 65025 + 1);
  localparam int WSW  = $clog2(MAX_TILE * MAX_TILE * 255 + 1);
  localparam int WQW  = $clog2(MAX_TILE * MAX_TILE * 65025 + 1);
  localparam int T2W  = $clog2(MAX_TILE * MAX_TILE + 1);
  localparam int T4W  = 2 * T2W;
  localparam int AW   = T2W + WQW;
  localparam int BW   = 2 * WSW;
  localparam int NW   = (AW > BW) ? AW : BW;
  localparam int DVW  = NW + 8;

  typedef struct packed {
    logic [CQW-1:0] sq;
    logic [CSW-1:0] sum;
  } col_t;

  // configuration
  logic [FW_W-1:0] fw_q;
  logic [FH_W-1:0] fh_q;
  logic [TS_W-1:0] ts_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FW_RESET;
      fh_q <= FH_RESET;
      ts_q <= TS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  fw_q <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_q <= cfg_data_i[FH_W-1:0];
        CFG_TILE_SIZE:    ts_q <= cfg_data_i[TS_W-1:0];
        default: ;
      endcase
    end
  end

  logic [TW-1:0]    t_eff;
  logic [CW-1:0]    w_eff, wp;
  logic [FH_W-1:0]  h_eff;
  logic [ROW_W-1:0] hp;

  always_comb begin
    if (ts_q == '0) t_eff = TW'(1);
    else if (ts_q > MAX_TILE) t_eff = TW'(MAX_TILE);
    else t_eff = TW'(ts_q);
    if (fw_q == '0) w_eff = CW'(1);
    else if (fw_q > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(fw_q);
    h_eff = (fh_q == '0) ? FH_W'(1) : fh_q;
    wp = w_eff + CW'(t_eff) - CW'(1);
    hp = ROW_W'(h_eff) + ROW_W'(t_eff) - ROW_W'(1);
  end

  // control
  wlv_state_e state_q, state_d;
  logic acc, col_we, out_load;
  logic [QCNT_W-1:0] cnt_q;

  // position counters
  logic [CW-1:0]    col_q, c0, c1;
  logic [ROW_W-1:0] row_q, r0, r1;
  logic [SLW-1:0]   slot_q, s0, s1, oslot;
  logic [TW:0]      os_w;

  function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] s);
    return (s == SLW'(MAX_TILE - 1)) ? '0 : s + SLW'(1);
  endfunction

  always_comb begin
    c0 = col_q;
    r0 = row_q;
    s0 = slot_q;
    if (col_q >= wp) begin
      c0 = '0;
      r0 = row_q + ROW_W'(1);
      s0 = slot_inc(slot_q);
    end
    if (r0 >= hp) begin
      r0 = '0;
      s0 = '0;
    end
    c1 = c0 + CW'(1);
    r1 = r0;
    s1 = s0;
    if (c1 >= wp) begin
      c1 = '0;
      r1 = r0 + ROW_W'(1);
      s1 = slot_inc(s0);
      if (r1 >= hp) begin
        r1 = '0;
        s1 = '0;
      end
    end
    os_w = (TW+1)'(s0) + (TW+1)'(MAX_TILE) - (TW+1)'(t_eff);
    if ((TW+1)'(s0) >= (TW+1)'(t_eff)) os_w = (TW+1)'(s0) - (TW+1)'(t_eff);
    oslot = os_w[SLW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (acc) begin
      col_q  <= c1;
      row_q  <= r1;
      slot_q <= s1;
    end
  end

  // accepted beat
  logic [PIX_W-1:0] pix_w, pix_q;
  logic [CW-1:0]    c_q;
  logic r_first_q, r_full_q, c_first_q, c_full_q, res_q, last_q;

  assign pix_w = (r0 < ROW_W'(h_eff) && c0 < w_eff) ? s_axis_tdata_i : '0;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      pix_q     <= pix_w;
      c_q       <= c0;
      r_first_q <= (r0 == '0);
      r_full_q  <= (r0 >= ROW_W'(t_eff));
      c_first_q <= (c0 == '0);
      c_full_q  <= (c0 >= CW'(t_eff));
      res_q     <= (r0 + ROW_W'(1) >= ROW_W'(t_eff)) && (c0 + CW'(1) >= CW'(t_eff));
      last_q    <= (r0 == hp - ROW_W'(1)) && (c0 == wp - CW'(1));
    end
  end

  // line store and column-sum store
  logic [PIX_W-1:0] line_mem [MAX_TILE*PW];
  col_t             col_mem  [PW];
  logic [PIX_W-1:0] ls_rd_q;
  col_t             cs_rd_q, col_wd;
  logic [LAW-1:0]   ls_wa, ls_ra;

  assign ls_wa = LAW'(s0) * LAW'(PW) + LAW'(c0);
  assign ls_ra = LAW'(oslot) * LAW'(PW) + LAW'(c0);

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ls_rd_q         <= line_mem[ls_ra];
      line_mem[ls_wa] <= pix_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) cs_rd_q <= col_mem[CAW'(c0)];
    if (col_we) col_mem[CAW'(c_q)] <= col_wd;
  end

  // column update
  col_t           cs_old;
  logic [15:0]    sq_in, sq_out;
  logic [PIX_W-1:0] ls_out;

  always_comb begin
    cs_old = r_first_q ? '0 : cs_rd_q;
    ls_out = r_full_q ? ls_rd_q : '0;
    sq_in  = 16'(pix_q) * 16'(pix_q);
    sq_out = 16'(ls_out) * 16'(ls_out);
    col_wd.sum = cs_old.sum + CSW'(pix_q) - CSW'(ls_out);
    col_wd.sq  = cs_old.sq + CQW'(sq_in) - CQW'(sq_out);
  end

  col_t ncol_q;
  col_t hist_q [MAX_TILE];
  col_t hout;
  logic [WSW-1:0] ws_q;
  logic [WQW-1:0] wsq_q;
  logic [T2W-1:0] t2_q;

  assign hout = c_full_q ? hist_q[SLW'(t_eff - TW'(1))] : '0;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) ncol_q <= col_wd;
    if (state_q == ST_UPD) begin
      ws_q  <= (c_first_q ? '0 : ws_q) + WSW'(ncol_q.sum) - WSW'(hout.sum);
      wsq_q <= (c_first_q ? '0 : wsq_q) + WQW'(ncol_q.sq) - WQW'(hout.sq);
      t2_q  <= T2W'(t_eff) * T2W'(t_eff);
      hist_q[0] <= ncol_q;
      for (int i = 1; i < MAX_TILE; i++) hist_q[i] <= hist_q[i-1];
    end
  end

  // variance: (T^2*S2 - S^2) * 256 / T^4
  logic [AW-1:0]    a_q;
  logic [BW-1:0]    b_q;
  logic [T4W-1:0]   t4_q, rem_q, rem_n;
  logic [NW-1:0]    num_w;
  logic [DVW-1:0]   dvd_w;
  logic [VAR_W-1:0] quo_q, dl_q;
  logic [T4W:0]     sh_w;

  assign num_w = (NW'(a_q) > NW'(b_q)) ? NW'(a_q) - NW'(b_q) : '0;
  assign dvd_w = {num_w, 8'd0};
  assign sh_w  = {rem_q, dl_q[VAR_W-1]};
  assign rem_n = (sh_w >= (T4W+1)'(t4_q)) ? T4W'(sh_w - (T4W+1)'(t4_q)) : sh_w[T4W-1:0];

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_MUL: begin
        a_q  <= AW'(t2_q) * AW'(wsq_q);
        b_q  <= BW'(ws_q) * BW'(ws_q);
        t4_q <= T4W'(t2_q) * T4W'(t2_q);
      end
      ST_SUB: begin
        rem_q <= T4W'(dvd_w >> VAR_W);
        dl_q  <= dvd_w[VAR_W-1:0];
        quo_q <= '0;
      end
      ST_DIV: begin
        rem_q <= rem_n;
        dl_q  <= {dl_q[VAR_W-2:0], 1'b0};
        quo_q <= {quo_q[VAR_W-2:0], (sh_w >= (T4W+1)'(t4_q))};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (state_q == ST_SUB) cnt_q <= '0;
    else if (state_q == ST_DIV) cnt_q <= cnt_q + QCNT_W'(1);
  end

  // state machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid_i) state_d = ST_READ;
      ST_READ: state_d = ST_UPD;
      ST_UPD:  state_d = res_q ? ST_MUL : ST_IDLE;
      ST_MUL:  state_d = ST_SUB;
      ST_SUB:  state_d = ST_DIV;
      ST_DIV:  if (cnt_q == QCNT_W'(VAR_W - 1)) state_d = ST_OUT;
      ST_OUT:  if (!m_axis_tvalid_o || m_axis_tready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    col_we          = (state_q == ST_READ);
    out_load        = (state_q == ST_OUT) && (!m_axis_tvalid_o || m_axis_tready_i);
  end

  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  // output register
  logic [VAR_W-1:0] var_q;
  logic             m_last_q, m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_valid_q <= 1'b0;
    else if (out_load) m_valid_q <= 1'b1;
    else if (m_axis_tready_i) m_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      var_q    <= quo_q;
      m_last_q <= last_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-VAR_W){1'b0}}, var_q};
  assign m_axis_tlast_o  = m_last_q;

endmodule

`default_nettype wire

@@ src/wlv_checker.sv @@
// ---------------------------------------------------------------------------
// wlv_checker
// Port-level checks for the windowed local variance block.
// ---------------------------------------------------------------------------
`default_nettype none

module wlv_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid_i,
  input wire logic                              s_axis_tready_o,
  input wire logic                              m_axis_tvalid_o,
  input wire logic                              m_axis_tready_i,
  input wire logic [wlv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  input wire logic                              m_axis_tlast_o
);
  import wlv_pkg::*;

  // held beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tlast_o))
    else $error("output beat dropped or changed while stalled");

  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid during reset");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_TDATA_W-1:VAR_W] == '0)
    else $error("tdata padding bits set");

  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !$rose(m_axis_tvalid_o))
    else $error("result appeared one cycle after input beat");

endmodule

bind windowed_local_variance wlv_checker u_wlv_checker (.*);

`default_nettype wire

@@ tb/wlv_checker.sv @@
// ---------------------------------------------------------------------------
// wlv_scoreboard
// Watches the pixel, result and register channels of the variance block,
// keeps its own line store and column sums, predicts each window variance
// and compares every result beat against the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module wlv_scoreboard (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_valid_i,
  input  wire logic                             s_ready_i,
  input  wire logic [wlv_pkg::PIX_W-1:0]        s_data_i,
  input  wire logic                             m_valid_i,
  input  wire logic                             m_ready_i,
  input  wire logic [wlv_pkg::OUT_TDATA_W-1:0]  m_data_i,
  input  wire logic                             m_last_i,
  input  wire logic                             cfg_valid_i,
  input  wire logic                             cfg_ready_i,
  input  wire logic [wlv_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [wlv_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output int                                    errors_o,
  output int                                    pending_o,
  output int                                    results_o
);
  import wlv_pkg::*;

  localparam int MT = MAX_TILE_DEF;
  localparam int PW = MAX_WIDTH_DEF + MAX_TILE_DEF - 1;

  typedef struct packed {
    logic [VAR_W-1:0] variance;
    logic             last;
  } var_result_t;

  logic [FW_W-1:0] fw;
  logic [FH_W-1:0] fh;
  logic [TS_W-1:0] ts;
  logic [7:0]      lines [MT*PW];
  int unsigned     col_s  [PW];
  int unsigned     col_s2 [PW];
  int unsigned     row, col;
  var_result_t     expected_q [$];

  assign pending_o = expected_q.size();

  task automatic predict_pixel(input logic [7:0] pix);
    int unsigned t, w, h, wp, hp, v, s, s2, k, ws, ws2;
    longint unsigned t2, a, b, num, q;
    var_result_t res;
    t = (ts == 0) ? 1 : (ts > MT ? MT : ts);
    w = (fw == 0) ? 1 : (fw > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : fw);
    h = (fh == 0) ? 1 : fh;
    wp = w + t - 1;
    hp = h + t - 1;
    if (col >= wp) begin col = 0; row++; end
    if (row >= hp) row = 0;
    v = (row < h && col < w) ? pix : 0;
    lines[(row % MT) * PW + col] = 8'(v);
    s = 0; s2 = 0;
    for (k = 0; k < t; k++) begin
      v = lines[((row + MT - k) % MT) * PW + col];
      s += v; s2 += v * v;
    end
    col_s[col] = s;
    col_s2[col] = s2;
    if (row + 1 >= t && col + 1 >= t) begin
      ws = 0; ws2 = 0;
      for (k = 0; k < t; k++) begin
        ws += col_s[col - k];
        ws2 += col_s2[col - k];
      end
      t2 = t * t;
      a = t2 * ws2;
      b = longint'(ws) * ws;
      num = a > b ? a - b : 0;
      q = (num << 8) / (t2 * t2);
      if (q > 64'h3FFFFF) q = 64'h3FFFFF;
      res.variance = q[VAR_W-1:0];
      res.last = (row == hp - 1 && col == wp - 1);
      expected_q.insert(expected_q.size(), res);
    end
    col++;
    if (col >= wp) begin
      col = 0; row++;
      if (row >= hp) row = 0;
    end
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    var_result_t got;
    int bad;
    if (!rst_ni) begin
      fw <= FW_RESET; fh <= FH_RESET; ts <= TS_RESET;
      row = 0; col = 0;
      for (int i = 0; i < MT*PW; i++) lines[i] = 0;
      for (int i = 0; i < PW; i++) begin col_s[i] = 0; col_s2[i] = 0; end
      expected_q.delete();
      errors_o <= 0;
      results_o <= 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        results_o <= results_o + 1;
        if (expected_q.size() == 0) begin
          $error("unexpected result beat: variance_q8=%0d", m_data_i[VAR_W-1:0]);
          errors_o <= errors_o + 1;
        end else begin
          got = expected_q.pop_front();
          bad = 0;
          if (m_data_i[VAR_W-1:0] !== got.variance) begin
            $error("variance_q8: expected %0d, actual %0d", got.variance,
                   m_data_i[VAR_W-1:0]);
            bad++;
          end
          if (m_last_i !== got.last) begin
            $error("frame_last: expected %0d, actual %0d", got.last, m_last_i);
            bad++;
          end
          errors_o <= errors_o + bad;
        end
      end
      if (s_valid_i && s_ready_i) predict_pixel(s_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FRAME_WIDTH:  fw <= cfg_data_i[FW_W-1:0];
          CFG_FRAME_HEIGHT: fh <= cfg_data_i[FH_W-1:0];
          CFG_TILE_SIZE:    ts <= cfg_data_i[TS_W-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Drives whole padded frames through the variance block under a range of
// frame and tile settings, with random idling on both sides and one long
// output stall; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  import wlv_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0, s_tready;
  logic [PIX_W-1:0] s_tdata = '0;
  logic m_tvalid, m_tready = 1'b0, m_tlast;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int errors, pending, results;
  int send_idle = 7, recv_idle = 55;
  bit hold_off = 1'b0;
  int pixels_sent = 0, frames_sent = 0;

  always #5 clk_i = ~clk_i;

  windowed_local_variance DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tlast_o(m_tlast),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  wlv_scoreboard u_checker (
    .clk_i, .rst_ni,
    .s_valid_i(s_tvalid), .s_ready_i(s_tready), .s_data_i(s_tdata),
    .m_valid_i(m_tvalid), .m_ready_i(m_tready), .m_data_i(m_tdata),
    .m_last_i(m_tlast),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [7:0] pix);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1; s_tdata <= pix;
    do @(posedge clk_i); while (!s_tready);
    pixels_sent++;
  endtask

  // mode 0 random, 1 all max, 2 all zero, 3 checker of 0/255
  task automatic send_frame(input int w, input int h, input int t, input int mode);
    int wp, hp, tc, wc, hc;
    logic [7:0] p;
    tc = (t <= 0) ? 1 : ((t > MAX_TILE_DEF) ? MAX_TILE_DEF : t);
    wc = (w <= 0) ? 1 : ((w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w);
    hc = (h <= 0) ? 1 : h;
    wp = wc + tc - 1;
    hp = hc + tc - 1;
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_TILE_SIZE, CFG_DATA_W'(t));
    cfg_valid <= 1'b0;
    for (int r = 0; r < hp; r++)
      for (int c = 0; c < wp; c++) begin
        case (mode)
          1: p = 8'hFF;
          2: p = 8'h00;
          3: p = ((r + c) % 2) ? 8'hFF : 8'h00;
          default: p = 8'($urandom_range(255));
        endcase
        send_pixel(p);
      end
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    frames_sent++;
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes of value, tile and size
    send_frame(3, 2, 1, 1);
    send_frame(2, 2, 2, 3);
    send_frame(1, 1, 16, 2);
    send_frame(1, 1, 0, 1);
    send_frame(0, 0, 3, 0);
    // long output stall while pixels keep coming
    fork
      send_frame(6, 5, 3, 0);
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    while (pixels_sent < 1850) begin
      if (pixels_sent > 1200) begin send_idle = 0; recv_idle = 0; end
      else if (pixels_sent > 600) begin send_idle = 55; recv_idle = 7; end
      if ($urandom_range(19) == 0) send_frame($urandom_range(4, 8), 1, 17, 0);
      else send_frame($urandom_range(1, 9), $urandom_range(1, 5),
                      $urandom_range(1, 5), $urandom_range(3));
    end
    write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(640));
    write_reg(CFG_TILE_SIZE, CFG_DATA_W'(7));
    cfg_valid <= 1'b0;
    drain();
    $display("covered %0d frames, %0d pixels, %0d variance results",
             frames_sent, pixels_sent, results);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

`default_nettype wire
